### rtl/pltm_pkg.sv
package pltm_pkg;

  // Stream field widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned IN_TUSER_W = 1;
  localparam int unsigned OUT_TUSER_W = 4;

  // Input tdata field positions
  localparam int unsigned IN_FEAT_LSB  = 0;
  localparam int unsigned IN_POINT_LSB = 4;
  localparam int unsigned IN_VALUE_LSB = 12;

  // Output tuser field positions
  localparam int unsigned OUT_SAT_BIT = 2;
  localparam int unsigned OUT_ERR_BIT = 3;

  // Fraction bits of the Q16.16 format
  localparam int unsigned FRAC_W = 16;

  // Arithmetic widths
  localparam int unsigned NP_W   = 9;    // num_points register
  localparam int unsigned NI_W   = 9;    // segment count
  localparam int unsigned MAG_W  = 33;   // |sample - range_min|, |range span|
  localparam int unsigned DIV_W  = 58;   // quotient bits of the position divider
  localparam int unsigned POS_W  = 59;   // signed breakpoint position in Q16
  localparam int unsigned OFFF_W = 60;   // offset before clamping
  localparam int unsigned OFF_W  = 50;   // clamped offset
  localparam int unsigned OFF_LO_W = 25;
  localparam int unsigned SLOPE_W = 33;
  localparam int unsigned PROD_W = 84;

  // Config register indexes
  localparam logic [1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [1:0] CFG_NUM_POINTS = 2'd2;

  // Operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_BELOW  = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_t;

endpackage

### rtl/piecewise_linear_table_map.sv
// Channel   | Handshake                 | Payload
// s (in)    | s_tvalid / s_tready       | s_tdata: feature, point, value; s_tuser: operation
// m (out)   | m_tvalid / m_tready       | m_tdata: result; m_tuser: region, saturated, error
// cfg       | cfg_we                    | cfg_index, cfg_data
//
// One request is taken every cycle while the skid register is empty.
// The position divider has 58 stages, one quotient bit a stage.
// A table write takes the same path and gives no result.
// Reset is synchronous; the table memory is not cleared and needs no clearing pass.
// An output register and a skid register sit behind the pipeline; the pipeline stalls
// only while the skid register is full.
module piecewise_linear_table_map #(
  parameter int unsigned MAX_POINTS   = 256,
  parameter int unsigned MAX_FEATURES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [3:0] feature, [11:4] point, [43:12] value, [47:44] zero
  input  logic [pltm_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [0] operation
  input  logic [pltm_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] result
  output logic [pltm_pkg::DATA_W-1:0]       m_tdata,
  // [1:0] region, [2] saturated, [3] error
  output logic [pltm_pkg::OUT_TUSER_W-1:0]  m_tuser,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [pltm_pkg::DATA_W-1:0]       cfg_data
);
  import pltm_pkg::*;

  localparam int unsigned FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned PT_W   = $clog2(MAX_POINTS);
  localparam int unsigned DEPTH  = MAX_FEATURES * MAX_POINTS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef struct packed {
    logic              op;
    logic              err;
    logic              neg;
    logic [FEAT_W-1:0] feat;
    logic [PT_W-1:0]   pt;
    logic [DATA_W-1:0] val;
  } tag_t;

  typedef struct packed {
    logic              err;
    logic              sat;
    region_t           region;
    logic [DATA_W-1:0] result;
  } res_t;

  // Configuration
  logic [DATA_W-1:0] range_min;
  logic [DATA_W-1:0] range_max;
  logic [NP_W-1:0]   num_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min  <= '0;
      range_max  <= 32'h0001_0000;
      num_points <= NP_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_MIN:  range_min  <= cfg_data;
        CFG_RANGE_MAX:  range_max  <= cfg_data;
        CFG_NUM_POINTS: num_points <= cfg_data[NP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived config values; user holds them still while requests are in flight, unenforced.
  logic signed [MAG_W-1:0] span;
  logic [MAG_W-1:0]        dmag;
  logic [12:0]             n_clamp;
  logic [NI_W-1:0]         ni;

  assign span = $signed({range_max[DATA_W-1], range_max})
              - $signed({range_min[DATA_W-1], range_min});
  assign dmag = span[MAG_W-1] ? MAG_W'(-span) : MAG_W'(span);

  always_comb begin
    if (num_points < NP_W'(2))
      n_clamp = 13'd2;
    else if ({4'b0, num_points} > 13'(MAX_POINTS))
      n_clamp = 13'(MAX_POINTS);
    else
      n_clamp = {4'b0, num_points};
  end
  assign ni = NI_W'(n_clamp - 13'd1);

  // Index reduction tables
  logic [FEAT_W-1:0] feat_mod [16];
  logic [PT_W-1:0]   pt_mod   [256];

  for (genvar i = 0; i < 16; i++) begin : g_feat_mod
    assign feat_mod[i] = FEAT_W'(i % MAX_FEATURES);
  end
  for (genvar i = 0; i < 256; i++) begin : g_pt_mod
    assign pt_mod[i] = PT_W'(i % MAX_POINTS);
  end

  function automatic logic [ADDR_W-1:0] tbl_addr(logic [FEAT_W-1:0] f, logic [PT_W-1:0] p);
    tbl_addr = ADDR_W'(f) * ADDR_W'(MAX_POINTS) + ADDR_W'(p);
  endfunction

  // Pipeline advance: everything moves unless the skid register is holding a result.
  logic adv;
  logic skid_vld;
  assign adv      = !skid_vld;
  assign s_tready = adv;

  // Stage 1: input register
  logic st1_vld;
  tag_t st1_tag;

  always_ff @(posedge clk) begin
    if (rst)
      st1_vld <= 1'b0;
    else if (adv)
      st1_vld <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_tag.op   <= s_tuser[0];
      st1_tag.err  <= (span == '0);
      st1_tag.neg  <= 1'b0;
      st1_tag.feat <= feat_mod[s_tdata[IN_FEAT_LSB +: 4]];
      st1_tag.pt   <= pt_mod[s_tdata[IN_POINT_LSB +: 8]];
      st1_tag.val  <= s_tdata[IN_VALUE_LSB +: DATA_W];
    end
  end

  // Stage 2: distance from range_min, magnitude and quotient sign
  logic signed [MAG_W-1:0] diff;
  logic                    st2_vld;
  tag_t                    st1_fwd;
  tag_t                    st2_tag;
  logic [MAG_W-1:0]        st2_amag;

  assign diff = $signed({st1_tag.val[DATA_W-1], st1_tag.val})
              - $signed({range_min[DATA_W-1], range_min});

  always_comb begin
    st1_fwd     = st1_tag;
    st1_fwd.neg = diff[MAG_W-1] ^ span[MAG_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst)
      st2_vld <= 1'b0;
    else if (adv)
      st2_vld <= st1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_tag     <= st1_fwd;
      st2_amag    <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end
  end

  // Divider: entry 0 holds the scaled dividend, entry k+1 the state after quotient bit k.
  logic [DIV_W:0]   dv_vld;
  tag_t             dv_tag [DIV_W+1];
  logic [DIV_W-1:0] dv_num [DIV_W+1];
  logic [MAG_W-1:0] dv_rem [DIV_W+1];
  logic [DIV_W-1:0] dv_quo [DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst)
      dv_vld[0] <= 1'b0;
    else if (adv)
      dv_vld[0] <= st2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_tag[0] <= st2_tag;
      dv_num[0] <= {(42'(st2_amag) * 42'(ni)), {FRAC_W{1'b0}}};
      dv_rem[0] <= '0;
      dv_quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [MAG_W:0] trial;
    logic           ge;

    assign trial = {dv_rem[k], dv_num[k][DIV_W-1]};
    assign ge    = (trial >= {1'b0, dmag});

    always_ff @(posedge clk) begin
      if (rst)
        dv_vld[k+1] <= 1'b0;
      else if (adv)
        dv_vld[k+1] <= dv_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_tag[k+1] <= dv_tag[k];
        dv_num[k+1] <= {dv_num[k][DIV_W-2:0], 1'b0};
        dv_rem[k+1] <= ge ? MAG_W'(trial - {1'b0, dmag}) : trial[MAG_W-1:0];
        dv_quo[k+1] <= {dv_quo[k][DIV_W-2:0], ge};
      end
    end
  end

  // Signed floor of the position
  logic                    sp_vld;
  tag_t                    sp_tag;
  logic signed [POS_W-1:0] sp_p;
  logic signed [POS_W-1:0] quo_s;

  assign quo_s = $signed({1'b0, dv_quo[DIV_W]});

  always_ff @(posedge clk) begin
    if (rst)
      sp_vld <= 1'b0;
    else if (adv)
      sp_vld <= dv_vld[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_tag <= dv_tag[DIV_W];
      if (dv_tag[DIV_W].neg)
        sp_p <= -quo_s - POS_W'(|dv_rem[DIV_W]);
      else
        sp_p <= quo_s;
    end
  end

  // Segment selection, offset, and table access
  logic                     below;
  logic                     above;
  logic [PT_W-1:0]          base_pt;
  logic [PT_W-1:0]          other_pt;
  logic signed [OFFF_W-1:0] off_full;
  logic signed [OFF_W-1:0]  off_clamp;

  localparam logic signed [OFFF_W-1:0] OFF_LIM_F = OFFF_W'(64'sh1_0000_0000_0000);
  localparam logic signed [OFF_W-1:0]  OFF_LIM   = OFF_W'(64'sh1_0000_0000_0000);

  always_comb begin
    below = sp_p[POS_W-1];
    above = !below && (sp_p[POS_W-1:FRAC_W] >= (POS_W-FRAC_W)'(ni));
    if (below) begin
      base_pt  = '0;
      other_pt = PT_W'(1);
      off_full = OFFF_W'(sp_p);
    end else if (above) begin
      base_pt  = PT_W'(ni);
      other_pt = PT_W'(ni - NI_W'(1));
      off_full = OFFF_W'(sp_p) - $signed({(OFFF_W-NI_W-FRAC_W)'(0), ni, {FRAC_W{1'b0}}});
    end else begin
      base_pt  = sp_p[FRAC_W +: PT_W];
      other_pt = PT_W'(sp_p[FRAC_W +: PT_W] + PT_W'(1));
      off_full = $signed({(OFFF_W-FRAC_W)'(0), sp_p[FRAC_W-1:0]});
    end
    // Past this magnitude any nonzero slope already drives the sum out of range.
    if (off_full > OFF_LIM_F)
      off_clamp = OFF_LIM;
    else if (off_full < -OFF_LIM_F)
      off_clamp = -OFF_LIM;
    else
      off_clamp = OFF_W'(off_full);
  end

  logic [DATA_W-1:0] tbl_mem [DEPTH];
  logic [DATA_W-1:0] rd_base;
  logic [DATA_W-1:0] rd_other;

  // Write and reads of the same stage belong to one request, so order is kept.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sp_vld && sp_tag.op == OP_WRITE)
        tbl_mem[tbl_addr(sp_tag.feat, sp_tag.pt)] <= sp_tag.val;
      rd_base  <= tbl_mem[tbl_addr(sp_tag.feat, base_pt)];
      rd_other <= tbl_mem[tbl_addr(sp_tag.feat, other_pt)];
    end
  end

  logic                    sr_vld;
  logic                    sr_op;
  logic                    sr_err;
  region_t                 sr_region;
  logic signed [OFF_W-1:0] sr_off;

  always_ff @(posedge clk) begin
    if (rst)
      sr_vld <= 1'b0;
    else if (adv)
      sr_vld <= sp_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_op     <= sp_tag.op;
      sr_err    <= sp_tag.err;
      sr_region <= below ? REGION_BELOW : (above ? REGION_ABOVE : REGION_INSIDE);
      sr_off    <= off_clamp;
    end
  end

  // Slope
  logic                      ss_vld;
  logic                      ss_op;
  logic                      ss_err;
  region_t                   ss_region;
  logic signed [OFF_W-1:0]   ss_off;
  logic signed [SLOPE_W-1:0] ss_slope;
  logic signed [DATA_W-1:0]  ss_dbase;
  logic signed [SLOPE_W-1:0] ext_base;
  logic signed [SLOPE_W-1:0] ext_other;

  assign ext_base  = $signed({rd_base[DATA_W-1], rd_base});
  assign ext_other = $signed({rd_other[DATA_W-1], rd_other});

  always_ff @(posedge clk) begin
    if (rst)
      ss_vld <= 1'b0;
    else if (adv)
      ss_vld <= sr_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_op     <= sr_op;
      ss_err    <= sr_err;
      ss_region <= sr_region;
      ss_off    <= sr_off;
      ss_dbase  <= $signed(rd_base);
      ss_slope  <= (sr_region == REGION_ABOVE) ? ext_base - ext_other : ext_other - ext_base;
    end
  end

  // Partial products of offset times slope
  logic                               sm_vld;
  logic                               sm_op;
  logic                               sm_err;
  region_t                            sm_region;
  logic signed [DATA_W-1:0]           sm_dbase;
  logic signed [OFF_LO_W+SLOPE_W:0]   sm_pp_lo;
  logic signed [OFF_W-OFF_LO_W+SLOPE_W-1:0] sm_pp_hi;

  always_ff @(posedge clk) begin
    if (rst)
      sm_vld <= 1'b0;
    else if (adv)
      sm_vld <= ss_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_op     <= ss_op;
      sm_err    <= ss_err;
      sm_region <= ss_region;
      sm_dbase  <= ss_dbase;
      sm_pp_lo  <= $signed({1'b0, ss_off[OFF_LO_W-1:0]}) * ss_slope;
      sm_pp_hi  <= $signed(ss_off[OFF_W-1:OFF_LO_W]) * ss_slope;
    end
  end

  // Full product
  logic                     sz_vld;
  logic                     sz_op;
  logic                     sz_err;
  region_t                  sz_region;
  logic signed [DATA_W-1:0] sz_dbase;
  logic signed [PROD_W-1:0] sz_prod;

  always_ff @(posedge clk) begin
    if (rst)
      sz_vld <= 1'b0;
    else if (adv)
      sz_vld <= sm_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sz_op     <= sm_op;
      sz_err    <= sm_err;
      sz_region <= sm_region;
      sz_dbase  <= sm_dbase;
      sz_prod   <= (PROD_W'(sm_pp_hi) <<< OFF_LO_W) + PROD_W'(sm_pp_lo);
    end
  end

  // Sum, clipping and the empty-range override
  localparam logic signed [PROD_W-1:0] RES_MAX = PROD_W'(64'sh7fff_ffff);
  localparam logic signed [PROD_W-1:0] RES_MIN = -PROD_W'(64'sh8000_0000);

  logic signed [PROD_W-1:0] sum;
  res_t                     res_new;
  logic                     new_vld;

  assign sum     = PROD_W'(sz_dbase) + (sz_prod >>> FRAC_W);
  assign new_vld = sz_vld && (sz_op == OP_CONVERT);

  always_comb begin
    res_new.err    = 1'b0;
    res_new.region = sz_region;
    if (sz_err) begin
      res_new.err    = 1'b1;
      res_new.region = REGION_INSIDE;
      res_new.sat    = 1'b0;
      res_new.result = '0;
    end else if (sum > RES_MAX) begin
      res_new.sat    = 1'b1;
      res_new.result = 32'h7fff_ffff;
    end else if (sum < RES_MIN) begin
      res_new.sat    = 1'b1;
      res_new.result = 32'h8000_0000;
    end else begin
      res_new.sat    = 1'b0;
      res_new.result = sum[DATA_W-1:0];
    end
  end

  // Output register and skid register
  res_t out_res;
  res_t skid_res;
  logic take;

  assign take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        out_res  <= skid_res;
        skid_vld <= 1'b0;
      end
    end else if (!m_tvalid || take) begin
      m_tvalid <= new_vld;
      out_res  <= res_new;
    end else if (new_vld) begin
      skid_res <= res_new;
      skid_vld <= 1'b1;
    end
  end

  assign m_tdata = out_res.result;
  assign m_tuser = {out_res.err, out_res.sat, out_res.region};

endmodule

### rtl/pltm_check.sv
module pltm_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pltm_pkg::DATA_W-1:0]       m_tdata,
  input logic [pltm_pkg::OUT_TUSER_W-1:0]  m_tuser
);
  import pltm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_ERR_BIT] |-> m_tdata == '0 && m_tuser[OUT_SAT_BIT:0] == '0)
    else $error("empty range result is not zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_SAT_BIT] |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
    else $error("saturated result is not an extreme");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind piecewise_linear_table_map pltm_check u_pltm_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
